/* rtl/papp_pkg.sv */
`default_nettype none

package papp_pkg;

  // field widths
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned MEAS_W   = 24;
  localparam int unsigned ERR_W    = 25;
  localparam int unsigned DERIV_W  = 26;
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned DRIVE_W  = 15;
  localparam int unsigned CFG_IDX_W = 3;

  // register reset values
  localparam logic [ANGLE_W-1:0] STOW_RESET   = 16'd30000;
  localparam logic [ANGLE_W-1:0] MIDDLE_RESET = 16'd26800;
  localparam logic [ANGLE_W-1:0] SCORE_RESET  = 16'd14000;
  localparam logic [ANGLE_W-1:0] TIP_RESET    = 16'd10000;
  localparam logic [ANGLE_W-1:0] UNTIP_RESET  = 16'd6500;
  localparam logic [GAIN_W-1:0]  PROP_RESET   = 16'd512;
  localparam logic [GAIN_W-1:0]  INTEG_RESET  = 16'd0;
  localparam logic [GAIN_W-1:0]  DERIV_RESET  = 16'd0;

  // drive clamp in mV
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 15'sd12000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -15'sd12000;

  // error sum limits
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // preset indexes
  localparam logic [1:0] PRESET_STOW   = 2'd0;
  localparam logic [1:0] PRESET_MIDDLE = 2'd1;
  localparam logic [1:0] PRESET_SCORE  = 2'd2;

  // button commands; codes above untip do nothing
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_NEXT  = 3'd1,
    CMD_PREV  = 3'd2,
    CMD_TIP   = 3'd3,
    CMD_UNTIP = 3'd4
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOW   = 3'd0,
    REG_MIDDLE = 3'd1,
    REG_SCORE  = 3'd2,
    REG_TIP    = 3'd3,
    REG_UNTIP  = 3'd4,
    REG_PROP   = 3'd5,
    REG_INTEG  = 3'd6,
    REG_DERIV  = 3'd7
  } reg_idx_t;

  // fields that ride along with a beat to the output
  typedef struct packed {
    logic [ANGLE_W-1:0] target;
    logic               brake;
  } tag_t;

  // error terms handed from the command stage to the pid pipeline
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W-1:0]   sum;
    logic signed [DERIV_W-1:0] deriv;
    tag_t                      tag;
  } err_beat_t;

  // gain set for the multipliers
  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } gains_t;

endpackage

`default_nettype wire

/* rtl/papp_pid_pipe.sv */
`default_nettype none

module papp_pid_pipe (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire papp_pkg::err_beat_t  in_beat,
  input  wire papp_pkg::gains_t     gains,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [papp_pkg::DRIVE_W-1:0] out_drive,
  output papp_pkg::tag_t            out_tag
);

  // stage 2: partial products
  logic                s2_valid_r;
  logic signed [41:0]  p_r;
  logic signed [42:0]  d_r;
  logic [35:0]         il_r;
  logic signed [36:0]  ih_r;
  papp_pkg::tag_t      tag2_r;

  // stage 3: pairwise sums
  logic                s3_valid_r;
  logic signed [43:0]  pd_r;
  logic signed [56:0]  ii_r;
  papp_pkg::tag_t      tag3_r;

  // stage 4: full accumulator
  logic                s4_valid_r;
  logic signed [57:0]  acc_r;
  papp_pkg::tag_t      tag4_r;

  // stage 5: output register
  logic                s5_valid_r;
  logic signed [papp_pkg::DRIVE_W-1:0] drive_r;
  papp_pkg::tag_t      tag5_r;

  logic rdy2, rdy3, rdy4, rdy5;

  logic signed [41:0] p_nxt;
  logic signed [42:0] d_nxt;
  logic [35:0]        il_nxt;
  logic signed [36:0] ih_nxt;
  logic signed [43:0] pd_nxt;
  logic signed [56:0] ii_nxt;
  logic signed [57:0] acc_nxt;
  logic signed [57:0] biased;
  logic signed [49:0] quot;
  logic signed [papp_pkg::DRIVE_W-1:0] drive_nxt;

  // each stage loads when empty or when the one after it moves
  assign rdy5     = !s5_valid_r || !out_stall;
  assign rdy4     = !s4_valid_r || rdy5;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign in_ready = rdy2;

  // proportional and derivative products; integral term split into two 16 x 20 products
  assign p_nxt  = $signed({1'b0, gains.prop}) * in_beat.err;
  assign d_nxt  = $signed({1'b0, gains.deriv}) * in_beat.deriv;
  assign il_nxt = in_beat.sum[19:0] * gains.integ;
  assign ih_nxt = $signed(in_beat.sum[39:20]) * $signed({1'b0, gains.integ});

  assign pd_nxt = {{2{p_r[41]}}, p_r} + {d_r[42], d_r};
  assign ii_nxt = {ih_r, 20'd0} + {21'd0, il_r};

  assign acc_nxt = {{14{pd_r[43]}}, pd_r} + {ii_r[56], ii_r};

  // divide by 256 rounding toward zero, then clamp
  assign biased = acc_r + (acc_r[57] ? 58'sd255 : 58'sd0);
  assign quot   = biased[57:8];

  always_comb begin
    if (quot > 50'(papp_pkg::DRIVE_MAX)) begin
      drive_nxt = papp_pkg::DRIVE_MAX;
    end else if (quot < 50'(papp_pkg::DRIVE_MIN)) begin
      drive_nxt = papp_pkg::DRIVE_MIN;
    end else begin
      drive_nxt = quot[papp_pkg::DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (rdy2) s2_valid_r <= in_valid;
      if (rdy3) s3_valid_r <= s2_valid_r;
      if (rdy4) s4_valid_r <= s3_valid_r;
      if (rdy5) s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p_r    <= p_nxt;
      d_r    <= d_nxt;
      il_r   <= il_nxt;
      ih_r   <= ih_nxt;
      tag2_r <= in_beat.tag;
    end
    if (rdy3) begin
      pd_r   <= pd_nxt;
      ii_r   <= ii_nxt;
      tag3_r <= tag2_r;
    end
    if (rdy4) begin
      acc_r  <= acc_nxt;
      tag4_r <= tag3_r;
    end
    if (rdy5) begin
      drive_r <= drive_nxt;
      tag5_r  <= tag4_r;
    end
  end

  assign out_valid = s5_valid_r;
  assign out_drive = drive_r;
  assign out_tag   = tag5_r;

endmodule

`default_nettype wire

/* rtl/preset_arm_position_pid.sv */
`default_nettype none

// Preset arm position controller. Each input beat is one control tick: a
// button command (none, next preset, previous preset, tip toggle, untip
// toggle) and the measured arm angle in centidegrees. The command updates
// the target angle first; a PID stage with unsigned Q8.8 gains then turns
// target minus measured angle into a motor drive in mV, clamped to +-12000.
// The error sum saturates at 40 bits signed. brake_hold is high whenever the
// preset index is not stow. Every tick gives exactly one result beat.
// Throughput is one beat per clock while out_stall is low; an accepted input
// beat reaches its result through the five register stages: command and
// error update, partial products, pairwise sums, full accumulator, and the
// scaled and clamped output. Stages fill independently, so input keeps
// flowing while a result is stalled until the pipeline is full. The eight
// 16-bit settings are written through cfg_we / cfg_index / cfg_data; write
// them only while no tick is in flight. A new target value is picked up only
// at the next command that loads the target.

module preset_arm_position_pid (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input beat
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [2:0]                          in_command,
  input  wire logic signed [papp_pkg::MEAS_W-1:0]  in_measured_angle,
  // result beat
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [papp_pkg::DRIVE_W-1:0]      out_drive_mv,
  output logic                                     out_brake_hold,
  output logic [papp_pkg::ANGLE_W-1:0]             out_target_angle,
  // settings
  input  wire logic                                cfg_we,
  input  wire logic [papp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [papp_pkg::GAIN_W-1:0]         cfg_data
);

  // settings registers
  logic [papp_pkg::ANGLE_W-1:0] stow_r, middle_r, score_r, tip_r, untip_r;
  papp_pkg::gains_t             gains_r;

  // controller state
  logic [1:0]                          preset_idx_r;
  logic [papp_pkg::ANGLE_W-1:0]        target_r;
  logic                                tip_idle_r;
  logic                                untip_idle_r;
  logic signed [papp_pkg::SUM_W-1:0]   err_sum_r;
  logic signed [papp_pkg::ERR_W-1:0]   last_err_r;

  // next values after the command
  logic [1:0]                          preset_idx_nxt;
  logic [papp_pkg::ANGLE_W-1:0]        target_nxt;
  logic                                tip_idle_nxt;
  logic                                untip_idle_nxt;
  logic signed [papp_pkg::ERR_W-1:0]   err_nxt;
  logic signed [papp_pkg::SUM_W:0]     sum_wide;
  logic signed [papp_pkg::SUM_W-1:0]   err_sum_nxt;
  logic signed [papp_pkg::DERIV_W-1:0] deriv_nxt;

  // stage 1 register feeding the pid pipeline
  logic                  s1_valid_r;
  papp_pkg::err_beat_t   s1_r;
  papp_pkg::err_beat_t   s1_nxt;

  logic              pipe_ready;
  logic              s1_ready;
  logic              accept;
  papp_pkg::tag_t    out_tag;
  papp_pkg::cmd_t    cmd;

  assign s1_ready = !s1_valid_r || pipe_ready;
  assign in_stall = !s1_ready;
  assign accept   = in_valid && s1_ready;
  assign cmd      = papp_pkg::cmd_t'(in_command);

  // settings write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stow_r        <= papp_pkg::STOW_RESET;
      middle_r      <= papp_pkg::MIDDLE_RESET;
      score_r       <= papp_pkg::SCORE_RESET;
      tip_r         <= papp_pkg::TIP_RESET;
      untip_r       <= papp_pkg::UNTIP_RESET;
      gains_r.prop  <= papp_pkg::PROP_RESET;
      gains_r.integ <= papp_pkg::INTEG_RESET;
      gains_r.deriv <= papp_pkg::DERIV_RESET;
    end else if (cfg_we) begin
      case (papp_pkg::reg_idx_t'(cfg_index))
        papp_pkg::REG_STOW:   stow_r        <= cfg_data;
        papp_pkg::REG_MIDDLE: middle_r      <= cfg_data;
        papp_pkg::REG_SCORE:  score_r       <= cfg_data;
        papp_pkg::REG_TIP:    tip_r         <= cfg_data;
        papp_pkg::REG_UNTIP:  untip_r       <= cfg_data;
        papp_pkg::REG_PROP:   gains_r.prop  <= cfg_data;
        papp_pkg::REG_INTEG:  gains_r.integ <= cfg_data;
        papp_pkg::REG_DERIV:  gains_r.deriv <= cfg_data;
        default: ;
      endcase
    end
  end

  // command decode: preset stepping and tip/untip toggles
  always_comb begin
    preset_idx_nxt = preset_idx_r;
    target_nxt     = target_r;
    tip_idle_nxt   = tip_idle_r;
    untip_idle_nxt = untip_idle_r;
    case (cmd)
      papp_pkg::CMD_NEXT, papp_pkg::CMD_PREV: begin
        if (cmd == papp_pkg::CMD_NEXT) begin
          preset_idx_nxt = (preset_idx_r == papp_pkg::PRESET_SCORE) ?
                           papp_pkg::PRESET_STOW : preset_idx_r + 2'd1;
        end else begin
          preset_idx_nxt = (preset_idx_r == papp_pkg::PRESET_STOW) ?
                           papp_pkg::PRESET_SCORE : preset_idx_r - 2'd1;
        end
        case (preset_idx_nxt)
          papp_pkg::PRESET_MIDDLE: target_nxt = middle_r;
          papp_pkg::PRESET_SCORE:  target_nxt = score_r;
          default:                 target_nxt = stow_r;
        endcase
        tip_idle_nxt   = 1'b1;
        untip_idle_nxt = 1'b1;
      end
      papp_pkg::CMD_TIP: begin
        tip_idle_nxt   = !tip_idle_r;
        untip_idle_nxt = 1'b1;
        target_nxt     = tip_idle_r ? tip_r : stow_r;
      end
      papp_pkg::CMD_UNTIP: begin
        untip_idle_nxt = !untip_idle_r;
        tip_idle_nxt   = 1'b1;
        target_nxt     = untip_idle_r ? untip_r : stow_r;
      end
      default: ;
    endcase
  end

  // error, saturating error sum and derivative
  assign err_nxt  = $signed({9'd0, target_nxt})
                  - {in_measured_angle[papp_pkg::MEAS_W-1], in_measured_angle};
  assign sum_wide = {err_sum_r[papp_pkg::SUM_W-1], err_sum_r}
                  + {{16{err_nxt[papp_pkg::ERR_W-1]}}, err_nxt};

  always_comb begin
    if (sum_wide[papp_pkg::SUM_W] != sum_wide[papp_pkg::SUM_W-1]) begin
      err_sum_nxt = sum_wide[papp_pkg::SUM_W] ? papp_pkg::SUM_MIN : papp_pkg::SUM_MAX;
    end else begin
      err_sum_nxt = sum_wide[papp_pkg::SUM_W-1:0];
    end
  end

  assign deriv_nxt = {err_nxt[papp_pkg::ERR_W-1], err_nxt}
                   - {last_err_r[papp_pkg::ERR_W-1], last_err_r};

  always_comb begin
    s1_nxt.err        = err_nxt;
    s1_nxt.sum        = err_sum_nxt;
    s1_nxt.deriv      = deriv_nxt;
    s1_nxt.tag.target = target_nxt;
    s1_nxt.tag.brake  = (preset_idx_nxt != papp_pkg::PRESET_STOW);
  end

  // state moves only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_idx_r <= papp_pkg::PRESET_STOW;
      target_r     <= papp_pkg::STOW_RESET;
      tip_idle_r   <= 1'b1;
      untip_idle_r <= 1'b1;
      err_sum_r    <= '0;
      last_err_r   <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        preset_idx_r <= preset_idx_nxt;
        target_r     <= target_nxt;
        tip_idle_r   <= tip_idle_nxt;
        untip_idle_r <= untip_idle_nxt;
        err_sum_r    <= err_sum_nxt;
        last_err_r   <= err_nxt;
      end
      if (s1_ready) s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) s1_r <= s1_nxt;
  end

  // multiply, accumulate, scale and clamp
  papp_pid_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_ready  (pipe_ready),
    .in_beat   (s1_r),
    .gains     (gains_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_drive (out_drive_mv),
    .out_tag   (out_tag)
  );

  assign out_brake_hold   = out_tag.brake;
  assign out_target_angle = out_tag.target;

endmodule

`default_nettype wire
